### design/byte_ring_fifo_run_access_defines.svh
// ----------------------------------------------------------------------------
// Byte ring FIFO assertion macros
// Shared concurrent assertion forms, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef BYTE_RING_FIFO_RUN_ACCESS_DEFINES_SVH
`define BYTE_RING_FIFO_RUN_ACCESS_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BRFRA_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BRFRA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### design/brfra_pkg.sv
// ----------------------------------------------------------------------------
// Byte ring FIFO package
// Sizes, derived widths and request kind codes of the byte ring FIFO.
// ----------------------------------------------------------------------------
package brfra_pkg;

   localparam int CAPACITY = 1024;
   localparam int MAX_RUN  = 64;

   localparam int DATA_W = 8;
   localparam int KIND_W = 2;
   localparam int CNT_W  = 7;
   localparam int PTR_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int FILL_W = $clog2(CAPACITY + 1);
   localparam int WIDE_W = (FILL_W > CNT_W) ? FILL_W : CNT_W;
   localparam int SUM_W  = ((PTR_W > CNT_W) ? PTR_W : CNT_W) + 1;

   typedef enum logic [KIND_W-1:0] {
      KIND_START = 2'd0,
      KIND_BYTE  = 2'd1,
      KIND_DEQ   = 2'd2,
      KIND_PEEK  = 2'd3
   } kind_type;

endpackage

### design/byte_ring_fifo_run_access.sv
// ----------------------------------------------------------------------------
// Byte ring FIFO with run access
// Byte ring buffer with fill count, reserved enqueue runs, dequeue and peek.
// ----------------------------------------------------------------------------
//   Channel   Direction  Handshake          Payload
//   req_      in         req_valid/stall    kind, data_byte, count
//   rsp_      out        rsp_valid/stall    data_byte_out, byte_valid, granted, last
//
// Enqueue start and enqueue byte each give one result. A dequeue or peek of n
// bytes streams one byte per cycle out of the RAM read port unless rsp_stall
// holds it; the next request is taken once the last read data has left the skid.
// Reset is synchronous and clears pointers, fill count and run; the RAM is not cleared.
// rsp_stall holds the output register; one skid register catches RAM read data.
module byte_ring_fifo_run_access (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [brfra_pkg::KIND_W-1:0] req_kind,
   input  logic [brfra_pkg::DATA_W-1:0] req_data_byte,
   input  logic [brfra_pkg::CNT_W-1:0]  req_count,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [brfra_pkg::DATA_W-1:0] rsp_data_byte_out,
   output logic                         rsp_byte_valid,
   output logic [brfra_pkg::CNT_W-1:0]  rsp_granted,
   output logic                         rsp_last
);

   import brfra_pkg::*;

   typedef enum logic {
      ST_IDLE,
      ST_READ
   } state_type;

   state_type           state_ff, state_in;
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [FILL_W-1:0]   fill_ff, fill_in;
   logic [CNT_W-1:0]    run_ff, run_in;
   logic [PTR_W-1:0]    addr_ff, addr_in;
   logic [CNT_W-1:0]    idx_ff, idx_in;
   logic [CNT_W-1:0]    n_ff, n_in;
   logic                rd_pend_ff, rd_pend_in;
   logic                pend_last_ff, pend_last_in;
   logic                skid_valid_ff, skid_valid_in;
   logic [DATA_W-1:0]   skid_data_ff, skid_data_in;
   logic                skid_last_ff, skid_last_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]   rsp_data_ff, rsp_data_in;
   logic                rsp_bvalid_ff, rsp_bvalid_in;
   logic [CNT_W-1:0]    rsp_granted_ff, rsp_granted_in;
   logic                rsp_last_ff, rsp_last_in;

   kind_type            kind;
   logic                out_free;
   logic                req_fire;
   logic                rd_en;
   logic                issue_last;
   logic                wr_en;
   logic [DATA_W-1:0]   ram_q;
   logic [FILL_W-1:0]   free_space;
   logic [CNT_W-1:0]    start_grant;
   logic [CNT_W-1:0]    sat_count;
   logic [CNT_W-1:0]    read_n;
   logic [SUM_W-1:0]    ptr_sum;
   logic [PTR_W-1:0]    rd_ptr_adv;

   function automatic logic [PTR_W-1:0] next_pos(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] r;
      if (p == PTR_W'(CAPACITY - 1)) begin
         r = '0;
      end else begin
         r = p + PTR_W'(1);
      end
      return r;
   endfunction

   assign kind     = kind_type'(req_kind);
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !(state_ff == ST_IDLE && !rd_pend_ff && !skid_valid_ff && out_free);
   assign req_fire = req_valid && !req_stall;

   // A read is issued only when its data is sure to find a place next cycle.
   assign rd_en      = (state_ff == ST_READ) && !skid_valid_ff && !(rd_pend_ff && !out_free);
   assign issue_last = (idx_ff + CNT_W'(1)) == n_ff;
   assign wr_en      = req_fire && (kind == KIND_BYTE) && (run_ff != '0);

   assign free_space  = FILL_W'(CAPACITY) - fill_ff;
   assign start_grant = (req_count <= CNT_W'(MAX_RUN) &&
                         WIDE_W'(req_count) <= WIDE_W'(free_space)) ? req_count : '0;
   assign sat_count   = (req_count > CNT_W'(MAX_RUN)) ? CNT_W'(MAX_RUN) : req_count;
   assign read_n      = (WIDE_W'(sat_count) > WIDE_W'(fill_ff)) ? CNT_W'(fill_ff) : sat_count;
   assign ptr_sum     = SUM_W'(rd_ptr_ff) + SUM_W'(read_n);
   assign rd_ptr_adv  = (ptr_sum >= SUM_W'(CAPACITY)) ? PTR_W'(ptr_sum - SUM_W'(CAPACITY))
                                                      : PTR_W'(ptr_sum);

   brfra_ram #(
      .WIDTH (DATA_W),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_ptr_ff),
      .wr_data (req_data_byte),
      .rd_en   (rd_en),
      .rd_addr (addr_ff),
      .rd_data (ram_q)
   );

   always_comb begin
      state_in       = state_ff;
      wr_ptr_in      = wr_ptr_ff;
      rd_ptr_in      = rd_ptr_ff;
      fill_in        = fill_ff;
      run_in         = run_ff;
      addr_in        = addr_ff;
      idx_in         = idx_ff;
      n_in           = n_ff;
      rd_pend_in     = rd_en;
      pend_last_in   = pend_last_ff;
      skid_valid_in  = skid_valid_ff;
      skid_data_in   = skid_data_ff;
      skid_last_in   = skid_last_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_data_in    = rsp_data_ff;
      rsp_bvalid_in  = rsp_bvalid_ff;
      rsp_granted_in = rsp_granted_ff;
      rsp_last_in    = rsp_last_ff;

      // Byte results of a read: the skid register drains before new RAM data.
      if (skid_valid_ff && out_free) begin
         skid_valid_in  = 1'b0;
         rsp_valid_in   = 1'b1;
         rsp_data_in    = skid_data_ff;
         rsp_bvalid_in  = 1'b1;
         rsp_granted_in = n_ff;
         rsp_last_in    = skid_last_ff;
      end else if (rd_pend_ff) begin
         if (out_free) begin
            rsp_valid_in   = 1'b1;
            rsp_data_in    = ram_q;
            rsp_bvalid_in  = 1'b1;
            rsp_granted_in = n_ff;
            rsp_last_in    = pend_last_ff;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = ram_q;
            skid_last_in  = pend_last_ff;
         end
      end

      if (rd_en) begin
         pend_last_in = issue_last;
         addr_in      = next_pos(addr_ff);
         idx_in       = idx_ff + CNT_W'(1);
         if (issue_last) begin
            state_in = ST_IDLE;
         end
      end

      if (req_fire) begin
         rsp_valid_in   = 1'b1;
         rsp_data_in    = '0;
         rsp_bvalid_in  = 1'b0;
         rsp_granted_in = '0;
         rsp_last_in    = 1'b1;
         case (kind)
            KIND_START: begin
               // A new start gives up whatever the previous run still owed.
               run_in         = start_grant;
               rsp_granted_in = start_grant;
            end
            KIND_BYTE: begin
               if (run_ff != '0) begin
                  wr_ptr_in      = next_pos(wr_ptr_ff);
                  fill_in        = fill_ff + FILL_W'(1);
                  run_in         = run_ff - CNT_W'(1);
                  rsp_granted_in = CNT_W'(1);
               end
            end
            KIND_DEQ, KIND_PEEK: begin
               if (read_n != '0) begin
                  // The bytes stream out from the READ state instead.
                  rsp_valid_in = 1'b0;
                  state_in     = ST_READ;
                  n_in         = read_n;
                  idx_in       = '0;
                  addr_in      = rd_ptr_ff;
                  if (kind == KIND_DEQ) begin
                     rd_ptr_in = rd_ptr_adv;
                     fill_in   = fill_ff - FILL_W'(read_n);
                  end
               end
            end
            default: begin
               rsp_valid_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
         fill_ff       <= '0;
         run_ff        <= '0;
         rd_pend_ff    <= 1'b0;
         skid_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         wr_ptr_ff     <= wr_ptr_in;
         rd_ptr_ff     <= rd_ptr_in;
         fill_ff       <= fill_in;
         run_ff        <= run_in;
         rd_pend_ff    <= rd_pend_in;
         skid_valid_ff <= skid_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      addr_ff        <= addr_in;
      idx_ff         <= idx_in;
      n_ff           <= n_in;
      pend_last_ff   <= pend_last_in;
      skid_data_ff   <= skid_data_in;
      skid_last_ff   <= skid_last_in;
      rsp_data_ff    <= rsp_data_in;
      rsp_bvalid_ff  <= rsp_bvalid_in;
      rsp_granted_ff <= rsp_granted_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_data_byte_out = rsp_data_ff;
   assign rsp_byte_valid    = rsp_bvalid_ff;
   assign rsp_granted       = rsp_granted_ff;
   assign rsp_last          = rsp_last_ff;

   `include "byte_ring_fifo_run_access_defines.svh"

   `BRFRA_ASSERT_NOW(a_skid_excl, skid_valid_ff, !rd_pend_ff, "skid and read data both held")
   `BRFRA_ASSERT_NOW(a_reserve, 1'b1, (fill_ff + run_ff) <= CAPACITY, "run overbooks the buffer")
   `BRFRA_ASSERT_NEXT(a_read_slot, rd_en, !(rsp_valid_ff && skid_valid_ff && rd_pend_ff), "read data lost")
   `BRFRA_ASSERT_NOW(a_idle_accept, req_fire, !rd_pend_ff && !skid_valid_ff, "request taken mid read")

endmodule

### design/brfra_ram.sv
// ----------------------------------------------------------------------------
// Byte ring FIFO generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module brfra_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
